>>> rtl/core/assert_macros.svh
// assert_macros.svh: concurrent assertion macros shared by the checker files.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Expression never holds.
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("assertion failed");

`endif

>>> rtl/core/tlbm_pkg.sv
// tlbm_pkg: widths, codes and shared structs of the tile latch bank mapper.
// Depends on nothing.
package tlbm_pkg;

   localparam int ADDR_W    = 16;
   localparam int MADDR_W   = 21;
   localparam int DIVD_W    = 13;
   localparam int DIVS_W    = 14;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 14;
   localparam int CNT_W     = 4;

   typedef enum logic [1:0] {
      ACT_CPU_READ  = 2'd0,
      ACT_CPU_WRITE = 2'd1,
      ACT_PPU_READ  = 2'd2,
      ACT_PPU_WRITE = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      TGT_NONE    = 3'd0,
      TGT_OPEN    = 3'd1,
      TGT_PRG_ROM = 3'd2,
      TGT_PRG_RAM = 3'd3,
      TGT_CHR_ROM = 3'd4,
      TGT_CHR_RAM = 3'd5
   } target_type;

   typedef enum logic [2:0] {
      CSR_PRG_ROM_BANKS     = 3'd0,
      CSR_CHR_ROM_BANKS     = 3'd1,
      CSR_PRG_RAM_PRESENT   = 3'd2,
      CSR_CHR_RAM_BYTES     = 3'd3,
      CSR_INITIAL_MIRRORING = 3'd4
   } csr_index_type;

   // register window decode on CPU A15..A12
   localparam logic [3:0] WIN_PRG_SEL = 4'hA;
   localparam logic [3:0] WIN_LOW_FD  = 4'hB;
   localparam logic [3:0] WIN_LOW_FE  = 4'hC;
   localparam logic [3:0] WIN_HIGH_FD = 4'hD;
   localparam logic [3:0] WIN_HIGH_FE = 4'hE;
   localparam logic [3:0] WIN_MIRROR  = 4'hF;

   // tile rows that trip the latches (eight bytes each)
   localparam logic [15:0] LOW_FD_ADDR  = 16'h0FD8;
   localparam logic [15:0] LOW_FE_ADDR  = 16'h0FE8;
   localparam logic [15:0] HIGH_FD_ADDR = 16'h1FD8;
   localparam logic [15:0] HIGH_FE_ADDR = 16'h1FE8;

   // reset values of the configuration registers
   localparam logic [7:0]  RST_PRG_ROM_BANKS = 8'd16;
   localparam logic [7:0]  RST_CHR_ROM_BANKS = 8'd32;
   localparam logic        RST_PRG_RAM       = 1'b1;
   localparam logic [13:0] RST_CHR_RAM_BYTES = 14'd0;
   localparam logic        RST_MIRRORING     = 1'b0;

   // remainder unit command and status
   typedef struct packed {
      logic              start;
      logic [DIVD_W-1:0] dividend;
      logic [DIVS_W-1:0] divisor;
   } mod_cmd_type;

   typedef struct packed {
      logic              done;
      logic [DIVS_W-1:0] remainder;
   } mod_rsp_type;

endpackage

>>> rtl/core/tlbm_if.sv
// tlbm_req_if / tlbm_rsp_if: valid/ready channels of the mapper.
// Depends on tlbm_pkg.
interface tlbm_req_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  action;
   logic [tlbm_pkg::ADDR_W-1:0] bus_address;
   logic [7:0]                  write_data;

   modport source (output valid, action, bus_address, write_data, input ready);
   modport sink   (input valid, action, bus_address, write_data, output ready);
endinterface

interface tlbm_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [2:0]                   target;
   logic [tlbm_pkg::MADDR_W-1:0] mem_address;
   logic                         write_enable;
   logic [7:0]                   write_byte;
   logic                         mirror_vertical;

   modport source (output valid, target, mem_address, write_enable, write_byte,
                   mirror_vertical, input ready);
   modport sink   (input valid, target, mem_address, write_enable, write_byte,
                   mirror_vertical, output ready);
endinterface

>>> rtl/core/tile_latch_bank_mapper_top.sv
// Tile latch bank mapper: one CPU or PPU bus access per transaction, one result each.
// Accesses that need no bank reduction return in the cycle after acceptance; PRG ROM
// reads, CHR ROM reads and CHR RAM accesses pass through the shared bit-serial
// remainder unit (13 iterations) and return once it reports done. One access
// is in flight at a time: req ready is low from acceptance until the result
// transaction completes, and the next access is taken on the cycle after it.
// Latch updates from tile FD/FE reads take effect before that read's bank is
// chosen. Configuration writes take effect on the next cycle.
// Depends on tlbm_pkg, tlbm_if and tlbm_mod_unit.
module tile_latch_bank_mapper_top (
   input  logic                               clock,
   input  logic                               reset,
   tlbm_req_if.sink                           req_bus,
   tlbm_rsp_if.source                         rsp_bus,
   input  logic                               csr_we,
   input  logic [tlbm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tlbm_pkg::CSR_DAT_W-1:0]     csr_wdata
);

   typedef enum logic [1:0] {ST_IDLE, ST_CALC, ST_DONE} state_type;
   typedef enum logic [1:0] {KIND_PRG, KIND_CHR_ROM, KIND_CHR_RAM} kind_type;

   // configuration
   logic [7:0]  prg_banks_ff;
   logic [7:0]  chr_banks_ff;
   logic        prg_ram_ff;
   logic [13:0] chr_ram_bytes_ff;

   // mapper state
   logic [3:0] prg_sel_ff,  prg_sel_in;
   logic [4:0] low_fd_ff,   low_fd_in;
   logic [4:0] low_fe_ff,   low_fe_in;
   logic [4:0] high_fd_ff,  high_fd_in;
   logic [4:0] high_fe_ff,  high_fe_in;
   logic       low_latch_ff,  low_latch_in;
   logic       high_latch_ff, high_latch_in;
   logic       mirror_ff,     mirror_in;

   // sequencer and result
   state_type                      state_ff;
   kind_type                       kind_ff;
   logic [12:0]                    offset_ff;
   logic [2:0]                     target_ff;
   logic [tlbm_pkg::MADDR_W-1:0]   maddr_ff;
   logic                           we_ff;
   logic [7:0]                     wbyte_ff;

   // decode of the offered access
   logic                           accept;
   logic                           is_cpu;
   logic                           is_wr;
   logic [15:0]                    addr;
   logic [7:0]                     data;
   logic [2:0]                     tgt_dec;
   logic [tlbm_pkg::MADDR_W-1:0]   maddr_dec;
   logic                           we_dec;
   logic                           need_mod;
   kind_type                       kind_dec;
   logic [4:0]                     chr_bank;
   logic [9:0]                     three_n;
   logic [9:0]                     fixed_num;

   tlbm_pkg::mod_cmd_type mod_cmd;
   tlbm_pkg::mod_rsp_type mod_rsp;

   assign accept = req_bus.valid && req_bus.ready;
   assign addr   = req_bus.bus_address;
   assign data   = req_bus.write_data;
   assign is_cpu = (req_bus.action == tlbm_pkg::ACT_CPU_READ) ||
                   (req_bus.action == tlbm_pkg::ACT_CPU_WRITE);
   assign is_wr  = (req_bus.action == tlbm_pkg::ACT_CPU_WRITE) ||
                   (req_bus.action == tlbm_pkg::ACT_PPU_WRITE);
   assign three_n = {1'b0, prg_banks_ff, 1'b0} + {2'b00, prg_banks_ff};

   // access decode, state update and remainder operands
   always_comb begin
      tgt_dec         = tlbm_pkg::TGT_NONE;
      maddr_dec       = '0;
      we_dec          = 1'b0;
      need_mod        = 1'b0;
      kind_dec        = KIND_PRG;
      mod_cmd.dividend = '0;
      mod_cmd.divisor  = '0;
      fixed_num       = '0;
      prg_sel_in      = prg_sel_ff;
      low_fd_in       = low_fd_ff;
      low_fe_in       = low_fe_ff;
      high_fd_in      = high_fd_ff;
      high_fe_in      = high_fe_ff;
      low_latch_in    = low_latch_ff;
      high_latch_in   = high_latch_ff;
      mirror_in       = mirror_ff;
      chr_bank        = '0;

      if (is_cpu) begin
         if (addr[15:13] == 3'b011) begin
            // work RAM window
            if (prg_ram_ff) begin
               tgt_dec   = tlbm_pkg::TGT_PRG_RAM;
               maddr_dec = tlbm_pkg::MADDR_W'(addr[12:0]);
               we_dec    = is_wr;
            end else if (!is_wr) begin
               tgt_dec = tlbm_pkg::TGT_OPEN;
            end
         end else if (addr[15] && is_wr) begin
            // register writes
            unique case (addr[15:12])
               tlbm_pkg::WIN_PRG_SEL: prg_sel_in = data[3:0];
               tlbm_pkg::WIN_LOW_FD:  low_fd_in  = data[4:0];
               tlbm_pkg::WIN_LOW_FE:  low_fe_in  = data[4:0];
               tlbm_pkg::WIN_HIGH_FD: high_fd_in = data[4:0];
               tlbm_pkg::WIN_HIGH_FE: high_fe_in = data[4:0];
               tlbm_pkg::WIN_MIRROR:  mirror_in  = data[0];
               default: ;
            endcase
         end else if (addr[15]) begin
            // PRG ROM: switchable window then three fixed windows
            if (prg_banks_ff == '0) begin
               tgt_dec = tlbm_pkg::TGT_OPEN;
            end else begin
               tgt_dec  = tlbm_pkg::TGT_PRG_ROM;
               need_mod = 1'b1;
               kind_dec = KIND_PRG;
               unique case (addr[14:13])
                  2'd0: fixed_num = {6'd0, prg_sel_ff};
                  2'd1: fixed_num = three_n - 10'd3;
                  2'd2: fixed_num = three_n - 10'd2;
                  default: fixed_num = three_n - 10'd1;
               endcase
               mod_cmd.dividend = tlbm_pkg::DIVD_W'(fixed_num);
               mod_cmd.divisor  = tlbm_pkg::DIVS_W'(prg_banks_ff);
            end
         end
      end else if (addr[15:13] == 3'b000) begin
         if (!is_wr) begin
            // tile latches trip before this read picks its bank
            if (addr[15:3] == tlbm_pkg::LOW_FD_ADDR[15:3]) begin
               low_latch_in = 1'b0;
            end else if (addr[15:3] == tlbm_pkg::LOW_FE_ADDR[15:3]) begin
               low_latch_in = 1'b1;
            end
            if (addr[15:3] == tlbm_pkg::HIGH_FD_ADDR[15:3]) begin
               high_latch_in = 1'b0;
            end else if (addr[15:3] == tlbm_pkg::HIGH_FE_ADDR[15:3]) begin
               high_latch_in = 1'b1;
            end
            if (addr[12]) begin
               chr_bank = high_latch_in ? high_fe_ff : high_fd_ff;
            end else begin
               chr_bank = low_latch_in ? low_fe_ff : low_fd_ff;
            end
            if (chr_banks_ff != '0) begin
               tgt_dec          = tlbm_pkg::TGT_CHR_ROM;
               need_mod         = 1'b1;
               kind_dec         = KIND_CHR_ROM;
               mod_cmd.dividend = tlbm_pkg::DIVD_W'(chr_bank);
               mod_cmd.divisor  = tlbm_pkg::DIVS_W'(chr_banks_ff);
            end else if (chr_ram_bytes_ff != '0) begin
               tgt_dec          = tlbm_pkg::TGT_CHR_RAM;
               need_mod         = 1'b1;
               kind_dec         = KIND_CHR_RAM;
               mod_cmd.dividend = addr[12:0];
               mod_cmd.divisor  = chr_ram_bytes_ff;
            end
         end else if (chr_banks_ff == '0 && chr_ram_bytes_ff != '0) begin
            tgt_dec          = tlbm_pkg::TGT_CHR_RAM;
            we_dec           = 1'b1;
            need_mod         = 1'b1;
            kind_dec         = KIND_CHR_RAM;
            mod_cmd.dividend = addr[12:0];
            mod_cmd.divisor  = chr_ram_bytes_ff;
         end
      end
      mod_cmd.start = accept && need_mod;
   end

   tlbm_mod_unit u_mod (
      .clock (clock),
      .reset (reset),
      .cmd   (mod_cmd),
      .rsp   (mod_rsp)
   );

   // configuration registers and mapper state
   always_ff @(posedge clock) begin
      if (reset) begin
         prg_banks_ff     <= tlbm_pkg::RST_PRG_ROM_BANKS;
         chr_banks_ff     <= tlbm_pkg::RST_CHR_ROM_BANKS;
         prg_ram_ff       <= tlbm_pkg::RST_PRG_RAM;
         chr_ram_bytes_ff <= tlbm_pkg::RST_CHR_RAM_BYTES;
         mirror_ff        <= tlbm_pkg::RST_MIRRORING;
         prg_sel_ff       <= '0;
         low_fd_ff        <= '0;
         low_fe_ff        <= '0;
         high_fd_ff       <= '0;
         high_fe_ff       <= '0;
         low_latch_ff     <= 1'b1;
         high_latch_ff    <= 1'b1;
      end else begin
         if (accept) begin
            prg_sel_ff    <= prg_sel_in;
            low_fd_ff     <= low_fd_in;
            low_fe_ff     <= low_fe_in;
            high_fd_ff    <= high_fd_in;
            high_fe_ff    <= high_fe_in;
            low_latch_ff  <= low_latch_in;
            high_latch_ff <= high_latch_in;
            mirror_ff     <= mirror_in;
         end
         if (csr_we) begin
            unique case (csr_index)
               tlbm_pkg::CSR_PRG_ROM_BANKS:   prg_banks_ff     <= csr_wdata[7:0];
               tlbm_pkg::CSR_CHR_ROM_BANKS:   chr_banks_ff     <= csr_wdata[7:0];
               tlbm_pkg::CSR_PRG_RAM_PRESENT: prg_ram_ff       <= csr_wdata[0];
               tlbm_pkg::CSR_CHR_RAM_BYTES:   chr_ram_bytes_ff <= csr_wdata;
               // initial mirroring loads the live mirroring bit
               tlbm_pkg::CSR_INITIAL_MIRRORING: mirror_ff      <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   // sequencer with registered result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  target_ff <= tgt_dec;
                  maddr_ff  <= maddr_dec;
                  we_ff     <= we_dec;
                  wbyte_ff  <= we_dec ? data : 8'd0;
                  kind_ff   <= kind_dec;
                  offset_ff <= addr[12:0];
                  state_ff  <= need_mod ? ST_CALC : ST_DONE;
               end
            end
            ST_CALC: begin
               if (mod_rsp.done) begin
                  unique case (kind_ff)
                     KIND_PRG:
                        maddr_ff <= {mod_rsp.remainder[7:0], offset_ff};
                     KIND_CHR_ROM:
                        maddr_ff <= {1'b0, mod_rsp.remainder[7:0], offset_ff[11:0]};
                     default:
                        maddr_ff <= tlbm_pkg::MADDR_W'(mod_rsp.remainder[12:0]);
                  endcase
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (rsp_bus.ready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_bus.ready           = (state_ff == ST_IDLE);
   assign rsp_bus.valid           = (state_ff == ST_DONE);
   assign rsp_bus.target          = target_ff;
   assign rsp_bus.mem_address     = maddr_ff;
   assign rsp_bus.write_enable    = we_ff;
   assign rsp_bus.write_byte      = wbyte_ff;
   assign rsp_bus.mirror_vertical = mirror_ff;

endmodule

>>> rtl/core/tlbm_mod_unit.sv
// tlbm_mod_unit: shared restoring remainder unit, one dividend bit per cycle.
// Depends on tlbm_pkg. Divisor must be nonzero.
module tlbm_mod_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  tlbm_pkg::mod_cmd_type cmd,
   output tlbm_pkg::mod_rsp_type rsp
);

   typedef enum logic {ST_IDLE, ST_RUN} state_type;

   state_type                       state_ff;
   logic                            done_ff;
   logic [tlbm_pkg::CNT_W-1:0]      count_ff;
   logic [tlbm_pkg::DIVD_W-1:0]     quo_ff;
   logic [tlbm_pkg::DIVS_W-1:0]     rem_ff;
   logic [tlbm_pkg::DIVS_W-1:0]     div_ff;
   logic [tlbm_pkg::DIVS_W:0]       trial;
   logic [tlbm_pkg::DIVS_W-1:0]     rem_in;

   // shift in next dividend bit, subtract when it fits
   always_comb begin
      trial = {rem_ff, quo_ff[tlbm_pkg::DIVD_W-1]};
      if (trial >= {1'b0, div_ff}) begin
         rem_in = tlbm_pkg::DIVS_W'(trial - {1'b0, div_ff});
      end else begin
         rem_in = trial[tlbm_pkg::DIVS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd.start) begin
                  state_ff <= ST_RUN;
                  count_ff <= tlbm_pkg::CNT_W'(tlbm_pkg::DIVD_W - 1);
               end
            end
            ST_RUN: begin
               count_ff <= count_ff - 1'b1;
               if (count_ff == '0) begin
                  state_ff <= ST_IDLE;
                  done_ff  <= 1'b1;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && cmd.start) begin
         quo_ff <= cmd.dividend;
         div_ff <= cmd.divisor;
         rem_ff <= '0;
      end else if (state_ff == ST_RUN) begin
         quo_ff <= {quo_ff[tlbm_pkg::DIVD_W-2:0], 1'b0};
         rem_ff <= rem_in;
      end
   end

   assign rsp.done      = done_ff;
   assign rsp.remainder = rem_ff;

endmodule

>>> rtl/core/tlbm_checker.sv
// tlbm_checker: port-level assertions on the mapper, bound to the top level.
// Depends on tlbm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tlbm_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_target,
   input logic       rsp_write_enable,
   input logic [7:0] rsp_write_byte
);

   // a pending result holds until taken
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // one transaction in flight: no intake while a result is offered
   `ASSERT_NEVER(a_no_overlap, clock, reset, req_ready && rsp_valid)

   // intake closes right after a request transaction
   `ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)

   // strobes only go to RAM targets
   `ASSERT_IMPLIES(a_we_ram, clock, reset, rsp_valid && rsp_write_enable,
      rsp_target == tlbm_pkg::TGT_PRG_RAM || rsp_target == tlbm_pkg::TGT_CHR_RAM)

   // no stored byte without a strobe
   `ASSERT_IMPLIES(a_byte_zero, clock, reset, rsp_valid && !rsp_write_enable,
      rsp_write_byte == 8'd0)

endmodule

bind tile_latch_bank_mapper_top tlbm_checker u_tlbm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_target       (rsp_bus.target),
   .rsp_write_enable (rsp_bus.write_enable),
   .rsp_write_byte   (rsp_bus.write_byte)
);
